// ----- hw/rtl/atcp_pkg.sv -----
// Shared types, codes and character constants of the AT command line parser.
`default_nettype none
package atcp_pkg;

	localparam int MaxParamsDef  = 16;
	localparam int MaxNameLenDef = 31;

	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChQuery  = 8'h3F;
	localparam logic [7:0] ChEqual  = 8'h3D;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [7:0] ChEscape = 8'h5C;
	localparam logic [7:0] ChUpperA = 8'h41;
	localparam logic [7:0] ChLowerA = 8'h61;
	localparam logic [7:0] ChUpperT = 8'h54;
	localparam logic [7:0] ChLowerT = 8'h74;
	localparam logic [7:0] CaseBit  = 8'h20;

	typedef enum logic [3:0] {
		PH_A        = 4'd0,
		PH_T        = 4'd1,
		PH_AFTER_AT = 4'd2,
		PH_NAME     = 4'd3,
		PH_AFTER_EQ = 4'd4,
		PH_PARAM    = 4'd5,
		PH_ESC      = 4'd6,
		PH_CR       = 4'd7,
		PH_LF       = 4'd8,
		PH_SKIP     = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_TEST  = 3'd1,
		OP_QUERY = 3'd2,
		OP_SETUP = 3'd3,
		OP_EXEC  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ROLE_SKIP  = 3'd0,
		ROLE_AT    = 3'd1,
		ROLE_PLUS  = 3'd2,
		ROLE_NAME  = 3'd3,
		ROLE_OPER  = 3'd4,
		ROLE_PARAM = 3'd5,
		ROLE_COMMA = 3'd6,
		ROLE_TERM  = 3'd7
	} role_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_AT     = 3'd1,
		ST_BAD_TERM  = 3'd2,
		ST_MANY_PARM = 3'd3,
		ST_LONG_NAME = 3'd4
	} status_t;

	// One result word.
	typedef struct packed {
		logic [7:0] norm_byte;
		role_t      role;
		logic [3:0] param_index;
		logic       line_done;
		status_t    status;
		op_t        operation;
		logic [4:0] name_length;
		logic [4:0] param_total;
	} res_t;

	function automatic logic is_name_char(input logic [7:0] b);
		return (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h21, 8'h25, 8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h5F});
	endfunction

	function automatic logic is_lower(input logic [7:0] b);
		return (b inside {[8'h61:8'h7A]});
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/atcp_step.sv -----
// Next-state and result logic for one line byte of the AT parser.
`default_nettype none
module atcp_step import atcp_pkg::*; #(
	parameter int MAX_PARAMS   = MaxParamsDef,
	parameter int MAX_NAME_LEN = MaxNameLenDef,
	localparam int NW = $clog2(MAX_NAME_LEN + 1),
	localparam int PW = $clog2(MAX_PARAMS + 1)
) (
	input  wire logic [7:0]    line_byte,
	input  wire phase_t        cur_phase,
	input  wire op_t           cur_op,
	input  wire logic [NW-1:0] cur_name,
	input  wire logic [PW-1:0] cur_param,
	output phase_t             nxt_phase,
	output op_t                nxt_op,
	output logic [NW-1:0]      nxt_name,
	output logic [PW-1:0]      nxt_param,
	output res_t               res
);

	logic          do_name;
	logic          do_param;
	logic          fail_en;
	status_t       fail_code;
	logic [PW-1:0] idx_n;
	logic [PW+4:0] idx_ext;
	logic [NW+4:0] name_ext;
	logic [PW+4:0] param_ext;

	assign idx_n     = (cur_param != '0) ? cur_param - PW'(1) : '0;
	assign idx_ext   = {5'b0, idx_n};
	assign name_ext  = {5'b0, cur_name};
	assign param_ext = {5'b0, cur_param};

	always_comb begin
		res = '{norm_byte: line_byte, role: ROLE_SKIP, param_index: 4'd0, line_done: 1'b0,
			status: ST_OK, operation: OP_NONE, name_length: 5'd0, param_total: 5'd0};
		nxt_phase = cur_phase;
		nxt_op    = cur_op;
		nxt_name  = cur_name;
		nxt_param = cur_param;
		do_name   = 1'b0;
		do_param  = 1'b0;
		fail_en   = 1'b0;
		fail_code = ST_OK;

		case (cur_phase)
			PH_A: begin
				nxt_op    = OP_NONE;
				nxt_name  = '0;
				nxt_param = '0;
				if (line_byte == ChUpperA || line_byte == ChLowerA) begin
					res.role  = ROLE_AT;
					nxt_phase = PH_T;
				end else begin
					fail_en   = 1'b1;
					fail_code = ST_NO_AT;
				end
			end
			PH_T: begin
				if (line_byte == ChUpperT || line_byte == ChLowerT) begin
					res.role  = ROLE_AT;
					nxt_phase = PH_AFTER_AT;
				end else begin
					fail_en   = 1'b1;
					fail_code = ST_NO_AT;
				end
			end
			PH_AFTER_AT: begin
				if (line_byte == ChPlus) begin
					res.role  = ROLE_PLUS;
					nxt_name  = NW'(1);
					nxt_phase = PH_NAME;
				end else begin
					do_name = 1'b1;
				end
			end
			PH_NAME: do_name = 1'b1;
			PH_AFTER_EQ: begin
				if (line_byte == ChQuery) begin
					res.role  = ROLE_OPER;
					nxt_op    = OP_TEST;
					nxt_param = '0;
					nxt_phase = PH_CR;
				end else begin
					nxt_phase = PH_PARAM;
					do_param  = 1'b1;
				end
			end
			PH_PARAM: do_param = 1'b1;
			PH_ESC: begin
				res.role        = ROLE_PARAM;
				res.param_index = idx_ext[3:0];
				nxt_phase       = PH_PARAM;
			end
			PH_CR: begin
				if (line_byte == ChCr) begin
					res.role  = ROLE_TERM;
					nxt_phase = PH_LF;
				end else begin
					fail_en   = 1'b1;
					fail_code = ST_BAD_TERM;
				end
			end
			PH_LF: begin
				if (line_byte == ChLf) begin
					res.role        = ROLE_TERM;
					res.line_done   = 1'b1;
					res.operation   = (cur_op == OP_NONE) ? OP_EXEC : cur_op;
					res.name_length = name_ext[4:0];
					res.param_total = param_ext[4:0];
					nxt_phase       = PH_A;
					nxt_op          = OP_NONE;
					nxt_name        = '0;
					nxt_param       = '0;
				end else begin
					fail_en   = 1'b1;
					fail_code = ST_BAD_TERM;
				end
			end
			default: begin
				// drop bytes through the next LF
				if (line_byte == ChLf) nxt_phase = PH_A;
				nxt_op    = OP_NONE;
				nxt_name  = '0;
				nxt_param = '0;
			end
		endcase

		if (do_name) begin
			if (is_name_char(line_byte)) begin
				if (cur_name >= NW'(MAX_NAME_LEN)) begin
					fail_en   = 1'b1;
					fail_code = ST_LONG_NAME;
				end else begin
					if (is_lower(line_byte)) res.norm_byte = line_byte & ~CaseBit;
					res.role  = ROLE_NAME;
					nxt_name  = cur_name + NW'(1);
					nxt_phase = PH_NAME;
				end
			end else if (line_byte == ChQuery) begin
				res.role  = ROLE_OPER;
				nxt_op    = OP_QUERY;
				nxt_phase = PH_CR;
			end else if (line_byte == ChEqual) begin
				res.role  = ROLE_OPER;
				nxt_op    = OP_SETUP;
				nxt_param = PW'(1);
				nxt_phase = PH_AFTER_EQ;
			end else if (line_byte == ChCr) begin
				res.role  = ROLE_TERM;
				nxt_phase = PH_LF;
			end else begin
				fail_en   = 1'b1;
				fail_code = ST_BAD_TERM;
			end
		end

		if (do_param) begin
			if (line_byte == ChEscape) begin
				res.role        = ROLE_PARAM;
				res.param_index = idx_ext[3:0];
				nxt_phase       = PH_ESC;
			end else if (line_byte == ChComma) begin
				if (cur_param >= PW'(MAX_PARAMS)) begin
					fail_en   = 1'b1;
					fail_code = ST_MANY_PARM;
				end else begin
					res.role        = ROLE_COMMA;
					res.param_index = idx_ext[3:0];
					nxt_param       = cur_param + PW'(1);
				end
			end else if (line_byte == ChCr) begin
				res.role  = ROLE_TERM;
				nxt_phase = PH_LF;
			end else if (line_byte == ChLf) begin
				fail_en   = 1'b1;
				fail_code = ST_BAD_TERM;
			end else begin
				res.role        = ROLE_PARAM;
				res.param_index = idx_ext[3:0];
			end
		end

		if (fail_en) begin
			res.role        = ROLE_SKIP;
			res.param_index = 4'd0;
			res.line_done   = 1'b1;
			res.status      = fail_code;
			res.operation   = OP_NONE;
			res.name_length = name_ext[4:0];
			res.param_total = param_ext[4:0];
			nxt_phase       = (line_byte == ChLf) ? PH_A : PH_SKIP;
			nxt_op          = OP_NONE;
			nxt_name        = '0;
			nxt_param       = '0;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/at_command_line_parser_top.sv -----
// Top level of the AT command line parser: input stage, line state and result stage.
//
//   channel  handshake                    payload
//   line     line_valid / line_ready      line_byte
//   result   result_valid / result_ready  norm_byte role param_index line_done
//                                         status operation name_length param_total
//
// One result word per line byte. A byte is held in the input register, then the step
// logic updates the line state and loads the result register; one byte per cycle is
// sustained while result_ready is high. Reset returns the parser to expecting A.
// A stalled result holds the result register; an empty input register still takes one
// more byte, and the line state advances only when a byte moves into the result stage.
`default_nettype none
module at_command_line_parser_top import atcp_pkg::*; #(
	parameter int MAX_PARAMS   = MaxParamsDef,
	parameter int MAX_NAME_LEN = MaxNameLenDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       line_valid,
	output logic            line_ready,
	input  wire logic [7:0] line_byte,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [7:0]      norm_byte,
	output logic [2:0]      role,
	output logic [3:0]      param_index,
	output logic            line_done,
	output logic [2:0]      status,
	output logic [2:0]      operation,
	output logic [4:0]      name_length,
	output logic [4:0]      param_total
);

	localparam int NW = $clog2(MAX_NAME_LEN + 1);
	localparam int PW = $clog2(MAX_PARAMS + 1);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          valid_s2;
	res_t          res_s2;
	logic          adv;

	phase_t        phase_q;
	op_t           op_q;
	logic [NW-1:0] name_q;
	logic [PW-1:0] param_q;

	phase_t        nxt_phase;
	op_t           nxt_op;
	logic [NW-1:0] nxt_name;
	logic [PW-1:0] nxt_param;
	res_t          res_d;

	assign adv        = valid_s1 && (!valid_s2 || result_ready);
	assign line_ready = !valid_s1 || adv;

	atcp_step #(
		.MAX_PARAMS  (MAX_PARAMS),
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_step (
		.line_byte(byte_s1),
		.cur_phase(phase_q),
		.cur_op   (op_q),
		.cur_name (name_q),
		.cur_param(param_q),
		.nxt_phase(nxt_phase),
		.nxt_op   (nxt_op),
		.nxt_name (nxt_name),
		.nxt_param(nxt_param),
		.res      (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_A;
			op_q     <= OP_NONE;
			name_q   <= '0;
			param_q  <= '0;
		end else begin
			if (line_ready) valid_s1 <= line_valid;
			if (adv) begin
				valid_s2 <= 1'b1;
				phase_q  <= nxt_phase;
				op_q     <= nxt_op;
				name_q   <= nxt_name;
				param_q  <= nxt_param;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (line_ready && line_valid) byte_s1 <= line_byte;
		if (adv) res_s2 <= res_d;
	end

	assign result_valid = valid_s2;
	assign norm_byte    = res_s2.norm_byte;
	assign role         = res_s2.role;
	assign param_index  = res_s2.param_index;
	assign line_done    = res_s2.line_done;
	assign status       = res_s2.status;
	assign operation    = res_s2.operation;
	assign name_length  = res_s2.name_length;
	assign param_total  = res_s2.param_total;

endmodule
`default_nettype wire
